>>> hw/rtl/fsd_pkg.sv
// Package with shared types, constants and conversion functions of the frame deframer.
package fsd_pkg;
  localparam int MAX_CHANNELS = 16;
  localparam int PAYLOAD_DEPTH = 128;
  localparam int MARKER_BYTES = 4;
  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 5);
  localparam int MARK_TOP = (MARKER_BYTES < 4) ? MARKER_BYTES : 4;
  localparam int CH_TOP = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;

  localparam logic [2:0] REG_SAMPLE_TYPE = 3'd0;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [2:0] REG_HEAD_PATTERN = 3'd2;
  localparam logic [2:0] REG_HEAD_LENGTH = 3'd3;
  localparam logic [2:0] REG_END_PATTERN = 3'd4;
  localparam logic [2:0] REG_END_LENGTH = 3'd5;

  localparam logic [2:0] T_U8 = 3'd0;
  localparam logic [2:0] T_U16 = 3'd1;
  localparam logic [2:0] T_U32 = 3'd2;
  localparam logic [2:0] T_I8 = 3'd3;
  localparam logic [2:0] T_I16 = 3'd4;
  localparam logic [2:0] T_I32 = 3'd5;
  localparam logic [2:0] T_F32 = 3'd6;
  localparam logic [2:0] T_F64 = 3'd7;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] sample_type;
    logic [4:0] channel_count;
    logic [31:0] head_pattern;
    logic [2:0] head_length;
    logic [31:0] end_pattern;
    logic [2:0] end_length;
  } cfg_t;

  function automatic logic [2:0] clamp_len(input logic [2:0] len);
    logic [2:0] r;
    r = len;
    if (len == 3'd0) r = 3'd1;
    if (len > 3'(MARK_TOP)) r = 3'(MARK_TOP);
    return r;
  endfunction

  function automatic logic marker_hit(input logic [31:0] win, input logic [31:0] pat,
                                      input logic [2:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(len)) begin
        if (pat[8*i +: 8] != win[8*(int'(len) - 1 - i) +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [3:0] type_size(input logic [2:0] t);
    logic [3:0] s;
    case (t)
      T_U8, T_I8: s = 4'd1;
      T_U16, T_I16: s = 4'd2;
      T_F64: s = 4'd8;
      default: s = 4'd4;
    endcase
    return s;
  endfunction

  // Exact conversion of a 33-bit signed integer to double.
  function automatic logic [63:0] int_to_double(input logic signed [32:0] v);
    logic sgn;
    logic [32:0] mag;
    logic [5:0] p;
    logic [63:0] fr;
    sgn = v[32];
    mag = sgn ? 33'(-v) : 33'(v);
    p = 6'd0;
    for (int i = 0; i < 33; i++) if (mag[i]) p = 6'(i);
    fr = 64'(mag) << (6'd52 - p);
    if (mag == 33'd0) return {sgn, 63'd0};
    return {sgn, 11'(1023 + int'(p)), fr[51:0]};
  endfunction

  function automatic logic [63:0] single_to_double(input logic [31:0] f);
    logic [7:0] e;
    logic [22:0] m;
    logic [4:0] p;
    logic [51:0] fr;
    logic [63:0] sh;
    e = f[30:23];
    m = f[22:0];
    if (e == 8'hFF) begin
      fr = {m, 29'd0};
      if (m != 23'd0) fr[51] = 1'b1;
      return {f[31], 11'h7FF, fr};
    end
    if (e == 8'd0) begin
      if (m == 23'd0) return {f[31], 63'd0};
      p = 5'd0;
      for (int i = 0; i < 23; i++) if (m[i]) p = 5'(i);
      sh = 64'(m) << (6'd52 - 6'(p));
      return {f[31], 11'(874 + int'(p)), sh[51:0]};
    end
    return {f[31], 11'(int'(e) + 896), m, 29'd0};
  endfunction
endpackage

>>> hw/rtl/framed_sample_deframer.sv
// Top level of the marker-delimited frame deframer.
// Bytes are accepted one per cycle while not stalled; an end marker starts the sample burst.
// Each sample reads its bytes (1, 2, 4 or 8) from the payload RAM one per cycle, then waits
// for the conversion and a free output register; no word is accepted during the burst.
// Reset (synchronous, rst_n low) clears config, state, windows and cnt_r; RAM is not cleared.
module framed_sample_deframer (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [63:0] out_sample_value,
  output logic [3:0] out_channel,
  output logic out_last_of_frame,
  output logic out_incomplete,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import fsd_pkg::*;

  cfg_t cfg_r;
  state_t state_r, state_nxt;
  logic collecting_r, collecting_nxt;
  logic [31:0] win_r, win_nxt;
  logic [2:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [3:0] ch_r, ch_nxt;
  logic [4:0] n_r, n_nxt;
  logic [3:0] bi_r, bi_nxt;
  logic [63:0] raw_r, raw_nxt;
  logic short_r, short_nxt;
  logic conv_pend_r, conv_pend_nxt;
  logic [3:0] out_ch_r, out_ch_nxt;
  logic out_last_r, out_last_nxt, out_inc_r, out_inc_nxt;
  logic ovalid_r, ovalid_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic [2:0] rd_bi_r, rd_bi_nxt;
  logic rd_ok_r, rd_ok_nxt;

  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0] ram_rdata;
  logic [63:0] conv_value;
  logic [2:0] hlen, elen;
  logic [3:0] size;
  logic acc;
  logic [31:0] w;
  logic [2:0] f;
  logic [11:0] pos;
  logic end_hit, head_hit;

  fsd_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_byte), .rdata(ram_rdata)
  );
  fsd_convert u_conv (
    .clk(clk), .sample_type(cfg_r.sample_type), .raw(raw_r), .value(conv_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{3'd0, 5'd1, 32'd0, 3'd1, 32'd0, 3'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_TYPE: cfg_r.sample_type <= cfg_data[2:0];
        REG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_data[4:0];
        REG_HEAD_PATTERN: cfg_r.head_pattern <= cfg_data;
        REG_HEAD_LENGTH: cfg_r.head_length <= cfg_data[2:0];
        REG_END_PATTERN: cfg_r.end_pattern <= cfg_data;
        REG_END_LENGTH: cfg_r.end_length <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign hlen = clamp_len(cfg_r.head_length);
  assign elen = clamp_len(cfg_r.end_length);
  assign size = type_size(cfg_r.sample_type);
  assign in_stall = (state_r != ST_RUN);
  assign acc = in_valid && !in_stall;
  assign w = {win_r[23:0], in_byte};
  assign f = (fill_r < 3'(MARK_TOP)) ? fill_r + 3'd1 : fill_r;
  assign end_hit = (f >= elen) && marker_hit(w, cfg_r.end_pattern, elen);
  assign head_hit = (f >= hlen) && marker_hit(w, cfg_r.head_pattern, hlen);
  assign pos = 12'(ch_r) * 12'(size) + 12'(bi_r);

  always_comb begin
    state_nxt = state_r;
    collecting_nxt = collecting_r;
    win_nxt = win_r;
    fill_nxt = fill_r;
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    ch_nxt = ch_r;
    n_nxt = n_r;
    bi_nxt = bi_r;
    raw_nxt = raw_r;
    short_nxt = short_r;
    conv_pend_nxt = 1'b0;
    out_ch_nxt = out_ch_r;
    out_last_nxt = out_last_r;
    out_inc_nxt = out_inc_r;
    ovalid_nxt = ovalid_r && out_stall;
    rd_pend_nxt = 1'b0;
    rd_bi_nxt = rd_bi_r;
    rd_ok_nxt = 1'b0;
    ram_we = 1'b0;
    ram_addr = cnt_r[ADDR_W-1:0];
    if (rd_pend_r && rd_ok_r) raw_nxt[8*rd_bi_r +: 8] = ram_rdata;
    case (state_r)
      ST_RUN: begin
        if (acc) begin
          win_nxt = w;
          fill_nxt = f;
          if (!collecting_r) begin
            if (end_hit) begin
              win_nxt = '0; fill_nxt = '0;
            end else if (head_hit) begin
              collecting_nxt = 1'b1; win_nxt = '0; fill_nxt = '0; cnt_nxt = '0;
            end
          end else begin
            ram_we = (cnt_r < CNT_W'(PAYLOAD_DEPTH));
            if (cnt_r < CNT_W'(PAYLOAD_DEPTH + 4)) cnt_nxt = cnt_r + 1'b1;
            if (end_hit) begin
              len_nxt = cnt_nxt - CNT_W'(elen);
              if (len_nxt > CNT_W'(PAYLOAD_DEPTH)) len_nxt = CNT_W'(PAYLOAD_DEPTH);
              n_nxt = cfg_r.channel_count;
              if (n_nxt == 5'd0) n_nxt = 5'd1;
              if (n_nxt > 5'(CH_TOP)) n_nxt = 5'(CH_TOP);
              collecting_nxt = 1'b0; win_nxt = '0; fill_nxt = '0; cnt_nxt = '0;
              ch_nxt = '0; bi_nxt = '0; raw_nxt = '0; short_nxt = 1'b0;
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        ram_addr = pos[ADDR_W-1:0];
        rd_pend_nxt = 1'b1;
        rd_bi_nxt = bi_r[2:0];
        rd_ok_nxt = (pos < 12'(len_r));
        if (pos >= 12'(len_r)) short_nxt = 1'b1;
        if (bi_r + 4'd1 == size) begin
          bi_nxt = '0;
          state_nxt = ST_WAIT;
        end else begin
          bi_nxt = bi_r + 4'd1;
        end
      end
      ST_WAIT: begin
        if (!rd_pend_r) begin
          conv_pend_nxt = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!conv_pend_r && !ovalid_nxt) begin
          ovalid_nxt = 1'b1;
          out_ch_nxt = ch_r;
          out_last_nxt = (5'(ch_r) + 5'd1 == n_r);
          out_inc_nxt = short_r;
          raw_nxt = '0;
          short_nxt = 1'b0;
          if (5'(ch_r) + 5'd1 == n_r) begin
            state_nxt = ST_RUN;
          end else begin
            ch_nxt = ch_r + 4'd1;
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  logic [63:0] out_val_r, out_val_nxt;
  assign out_val_nxt = (state_r == ST_OUT && state_nxt != ST_OUT) ? conv_value : out_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      collecting_r <= 1'b0;
      win_r <= '0;
      fill_r <= '0;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      rd_pend_r <= 1'b0;
      conv_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      collecting_r <= collecting_nxt;
      win_r <= win_nxt;
      fill_r <= fill_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      rd_pend_r <= rd_pend_nxt;
      conv_pend_r <= conv_pend_nxt;
    end
    len_r <= len_nxt;
    ch_r <= ch_nxt;
    n_r <= n_nxt;
    bi_r <= bi_nxt;
    raw_r <= raw_nxt;
    short_r <= short_nxt;
    rd_bi_r <= rd_bi_nxt;
    rd_ok_r <= rd_ok_nxt;
    out_ch_r <= out_ch_nxt;
    out_last_r <= out_last_nxt;
    out_inc_r <= out_inc_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_sample_value = out_val_r;
  assign out_channel = out_ch_r;
  assign out_last_of_frame = out_last_r;
  assign out_incomplete = out_inc_r;

  a_stall_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> in_stall) else $error("word accepted during sample burst");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_value)))
    else $error("stalled sample changed");
  a_no_write_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> collecting_r) else $error("payload write while hunting");
endmodule

>>> hw/rtl/fsd_ram.sv
// Generic single-port synchronous RAM with registered read.
module fsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/fsd_convert.sv
// Registered conversion of an assembled raw sample to double bits.
module fsd_convert (
  input  logic clk,
  input  logic [2:0] sample_type,
  input  logic [63:0] raw,
  output logic [63:0] value
);
  import fsd_pkg::*;
  logic [63:0] value_nxt;
  always_comb begin
    case (sample_type)
      T_U8: value_nxt = int_to_double(33'(raw[7:0]));
      T_U16: value_nxt = int_to_double(33'(raw[15:0]));
      T_U32: value_nxt = int_to_double({1'b0, raw[31:0]});
      T_I8: value_nxt = int_to_double({{25{raw[7]}}, raw[7:0]});
      T_I16: value_nxt = int_to_double({{17{raw[15]}}, raw[15:0]});
      T_I32: value_nxt = int_to_double({raw[31], raw[31:0]});
      T_F32: value_nxt = single_to_double(raw[31:0]);
      default: value_nxt = raw;
    endcase
  end
  always_ff @(posedge clk) value <= value_nxt;
endmodule

>>> bench/fsd_checker.sv
// Checker for the frame deframer: predicts samples from accepted bytes and compares results.
`timescale 1ns / 1ps
module fsd_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [7:0] in_byte,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [63:0] out_sample_value,
  input  logic [3:0] out_channel,
  input  logic out_last_of_frame,
  input  logic out_incomplete,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int fail_count,
  output int pending
);
  import fsd_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic [3:0] chan;
    logic last;
    logic short_of;
  } sample_t;

  sample_t sample_q[$];

  logic [2:0] m_type;
  logic [4:0] m_chans;
  logic [31:0] m_head_pat, m_end_pat;
  logic [2:0] m_head_len, m_end_len;

  logic hunting_done;
  logic [31:0] head_win, end_win;
  int win_fill;
  logic [7:0] frame_bytes[PAYLOAD_DEPTH];
  int frame_count;

  function automatic int eff_len(input logic [2:0] len);
    int r;
    r = (len == 3'd0) ? 1 : int'(len);
    if (r > MARK_TOP) r = MARK_TOP;
    return r;
  endfunction

  function automatic logic pattern_seen(input logic [31:0] win, input logic [31:0] pat,
                                        input int len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < len; i++)
      if (pat[8*i +: 8] != win[8*(len - 1 - i) +: 8]) ok = 1'b0;
    return ok;
  endfunction

  function automatic logic [63:0] widen_single(input logic [31:0] f);
    logic [51:0] fr;
    logic [63:0] sh;
    int p;
    if (f[30:23] == 8'hFF) begin
      fr = {f[22:0], 29'd0};
      if (f[22:0] != 23'd0) fr[51] = 1'b1;
      return {f[31], 11'h7FF, fr};
    end
    if (f[30:23] == 8'd0) begin
      if (f[22:0] == 23'd0) return {f[31], 63'd0};
      p = 0;
      for (int i = 0; i < 23; i++) if (f[i]) p = i;
      sh = 64'(f[22:0]) << (52 - p);
      return {f[31], 11'(874 + p), sh[51:0]};
    end
    return {f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'd0};
  endfunction

  function automatic logic [63:0] to_double(input logic [63:0] raw, input logic [2:0] t);
    longint v;
    case (t)
      T_U8: v = longint'(raw[7:0]);
      T_U16: v = longint'(raw[15:0]);
      T_U32: v = longint'(raw[31:0]);
      T_I8: v = longint'($signed(raw[7:0]));
      T_I16: v = longint'($signed(raw[15:0]));
      T_I32: v = longint'($signed(raw[31:0]));
      T_F32: return widen_single(raw[31:0]);
      default: return raw;
    endcase
    return $realtobits($itor(v));
  endfunction

  task automatic clear_windows();
    head_win = '0;
    end_win = '0;
    win_fill = 0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    int hl, el, plen, sz, n;
    logic [63:0] raw;
    sample_t s;
    hl = eff_len(m_head_len);
    el = eff_len(m_end_len);
    head_win = {head_win[23:0], b};
    end_win = {end_win[23:0], b};
    if (win_fill < MARK_TOP) win_fill++;
    if (!hunting_done) begin
      if (win_fill >= el && pattern_seen(end_win, m_end_pat, el)) begin
        clear_windows();
      end else if (win_fill >= hl && pattern_seen(head_win, m_head_pat, hl)) begin
        hunting_done = 1'b1;
        clear_windows();
        frame_count = 0;
      end
      return;
    end
    if (frame_count < PAYLOAD_DEPTH) frame_bytes[frame_count] = b;
    if (frame_count < PAYLOAD_DEPTH + 4) frame_count++;
    if (win_fill >= el && pattern_seen(end_win, m_end_pat, el)) begin
      plen = frame_count - el;
      if (plen > PAYLOAD_DEPTH) plen = PAYLOAD_DEPTH;
      case (m_type)
        T_U8, T_I8: sz = 1;
        T_U16, T_I16: sz = 2;
        T_F64: sz = 8;
        default: sz = 4;
      endcase
      n = (m_chans == 5'd0) ? 1 : int'(m_chans);
      if (n > CH_TOP) n = CH_TOP;
      for (int k = 0; k < n; k++) begin
        raw = '0;
        s.short_of = 1'b0;
        for (int i = 0; i < sz; i++) begin
          if (k * sz + i < plen) raw[8*i +: 8] = frame_bytes[k * sz + i];
          else s.short_of = 1'b1;
        end
        s.value = to_double(raw, m_type);
        s.chan = 4'(k);
        s.last = (k + 1 == n);
        sample_q.push_back(s);
      end
      hunting_done = 1'b0;
      clear_windows();
      frame_count = 0;
    end
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (!rst_n) begin
      m_type = T_U8;
      m_chans = 5'd1;
      m_head_pat = '0;
      m_head_len = 3'd1;
      m_end_pat = '0;
      m_end_len = 3'd1;
      hunting_done = 1'b0;
      clear_windows();
      frame_count = 0;
      sample_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected word value=%h ch=%0d", $time, out_sample_value,
                   out_channel);
          fail_count++;
        end else begin
          e = sample_q.pop_front();
          if (e.value !== out_sample_value || e.chan !== out_channel ||
              e.last !== out_last_of_frame || e.short_of !== out_incomplete) begin
            $display("%0t: expected %h ch=%0d last=%b inc=%b, got %h ch=%0d last=%b inc=%b",
                     $time, e.value, e.chan, e.last, e.short_of, out_sample_value,
                     out_channel, out_last_of_frame, out_incomplete);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_TYPE: m_type = cfg_data[2:0];
          REG_CHANNEL_COUNT: m_chans = cfg_data[4:0];
          REG_HEAD_PATTERN: m_head_pat = cfg_data;
          REG_HEAD_LENGTH: m_head_len = cfg_data[2:0];
          REG_END_PATTERN: m_end_pat = cfg_data;
          REG_END_LENGTH: m_end_len = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_byte(in_byte);
    end
    pending = sample_q.size();
  end
endmodule

>>> bench/tb_top.sv
// Top of the frame deframer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import fsd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_sample_value;
  logic [3:0] out_channel;
  logic out_last_of_frame;
  logic out_incomplete;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycles = 0;
  int sent = 0;
  logic calm = 1'b0;
  int stall_left = 0;

  localparam int LIMIT = 600000;
  localparam int DRAIN = 16 * 11 + 40;

  always #5 clk = ~clk;

  framed_sample_deframer uut (.*);

  fsd_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end
  end

  function automatic int gap_len();
    if (calm) return 0;
    return ($urandom_range(0, 11) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
  endfunction

  task automatic send(input logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic setup(input logic [2:0] t, input logic [4:0] n, input logic [31:0] hp,
                       input logic [2:0] hl, input logic [31:0] ep, input logic [2:0] el);
    go_idle();
    write_reg(REG_SAMPLE_TYPE, 32'(t));
    write_reg(REG_CHANNEL_COUNT, 32'(n));
    write_reg(REG_HEAD_PATTERN, hp);
    write_reg(REG_HEAD_LENGTH, 32'(hl));
    write_reg(REG_END_PATTERN, ep);
    write_reg(REG_END_LENGTH, 32'(el));
    cfg_we <= 1'b0;
  endtask

  task automatic send_marker(input logic [31:0] pat, input logic [2:0] len);
    int l;
    l = (len == 3'd0) ? 1 : (len > 3'd4 ? 4 : int'(len));
    for (int i = 0; i < l; i++) send(pat[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] hp, input logic [2:0] hl,
                            input logic [31:0] ep, input logic [2:0] el, input int plen);
    send_marker(hp, hl);
    for (int i = 0; i < plen; i++) send(8'($urandom));
    send_marker(ep, el);
  endtask

  initial begin
    logic [2:0] t, hl, el;
    logic [4:0] n;
    logic [31:0] hp, ep;
    int plen;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Unsigned bytes: a full frame, one end marker while hunting, then a frame with a short payload.
    setup(T_U8, 5'd2, 32'h0000_00A5, 3'd1, 32'h0000_5A7E, 3'd2);
    send(8'hA5); send(8'h00); send(8'hFF); send(8'h7E); send(8'h5A);
    send(8'h7E); send(8'h5A); send(8'hA5); send(8'h80); send(8'h7E); send(8'h5A);

    // Float specials: subnormals and infinity; clamped lengths and channels.
    setup(T_F32, 5'd0, 32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd0);
    calm = 1'b1;
    send_marker(32'hFFFF_FFFF, 3'd4);
    send(8'h01); send(8'h00); send(8'hA0); send(8'hFF);
    send(8'h00);
    calm = 1'b0;
    setup(T_F32, 5'd31, 32'h0000_00C3, 3'd1, 32'h0000_003C, 3'd1);
    send(8'hC3);
    send(8'h01); send(8'h00); send(8'h00); send(8'h80);
    send(8'h00); send(8'h00); send(8'h80); send(8'hFF);
    send(8'h3C);

    while (sent < 145) begin
      t = 3'($urandom_range(0, 7));
      n = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 4));
      hl = 3'($urandom_range(0, 7));
      el = 3'($urandom_range(0, 7));
      hp = $urandom;
      ep = $urandom;
      if ($urandom_range(0, 3) == 0) hp = {4{8'h00}};
      if ($urandom_range(0, 3) == 0) ep = {4{8'hFF}};
      setup(t, n, hp, hl, ep, el);
      for (int f = 0; f < 3; f++) begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send(8'($urandom));
        plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 12);
        if ($urandom_range(0, 30) == 0) plen = $urandom_range(125, 134);
        send_frame(hp, hl, ep, el, plen);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
